### rtl/affine_transform_decompose_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine transform decomposition unit
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_DECOMPOSE_UNIT_ASSERT_SVH
`define AFFINE_TRANSFORM_DECOMPOSE_UNIT_ASSERT_SVH

// Same-cycle implication
`define ATDU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ATDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/atd_pkg.sv
// ----------------------------------------------------------------------------
// atd_pkg
// Shared constants, types and the arctangent table of the decomposition unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atd_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int IT_W         = $clog2(CORDIC_ITERS);

  localparam int DATA_W  = 32;
  localparam int ANG_W   = 19;
  localparam int SCALE_W = 31;
  localparam int UW      = FRAC_BITS + 2;   // signed unit vector element
  localparam int QW      = FRAC_BITS + 1;   // quotient bits, at most 1.0
  localparam int DIV_CW  = $clog2(QW);
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int XW      = 34;              // CORDIC x/y in Q30
  localparam int ZW      = 36;              // CORDIC angle accumulator in Q30
  localparam int KSH     = 30 - FRAC_BITS;

  localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Z_RND  = ZW'(64'd1 << (KSH - 1));

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 248;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CORNER   = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 36'sh03243F6A8;
      5'd1:  v = 36'sh01DAC6705;
      5'd2:  v = 36'sh00FADBAFC;
      5'd3:  v = 36'sh007F56EA6;
      5'd4:  v = 36'sh003FEAB76;
      5'd5:  v = 36'sh001FFD55B;
      5'd6:  v = 36'sh000FFFAAA;
      5'd7:  v = 36'sh0007FFF55;
      5'd8:  v = 36'sh0003FFFEA;
      5'd9:  v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF;
      5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF;
      5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF;
      5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF;
      5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF;
      5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF;
      5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF;
      5'd23: v = 36'sh00000007F;
      5'd24: v = 36'sh00000003F;
      5'd25: v = 36'sh00000001F;
      5'd26: v = 36'sh00000000F;
      5'd27: v = 36'sh000000008;
      5'd28: v = 36'sh000000004;
      5'd29: v = 36'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/atd_sqrt.sv
// ----------------------------------------------------------------------------
// atd_sqrt
// Digit-serial floor square root: two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [atd_pkg::RAD_W-1:0]   radicand,
  output atd_pkg::unit_stat_t         stat,
  output logic [atd_pkg::ROOT_W-1:0]  root
);
  import atd_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              fit;

  // Bring down the next digit pair and try the new root bit
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fit    = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // Flag the cycle after the last digit
      done_r <= busy_r && !start && (cnt_r == CNT_W'(ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= fit ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], fit};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

### rtl/atd_div.sv
// ----------------------------------------------------------------------------
// atd_div
// Bit-serial restoring divider for a magnitude no larger than its divisor:
// one quotient bit per cycle, FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [atd_pkg::DATA_W-1:0]  num,
  input  logic [atd_pkg::DATA_W-1:0]  den,
  output atd_pkg::unit_stat_t         stat,
  output logic [atd_pkg::QW-1:0]      quo
);
  import atd_pkg::*;

  logic [DATA_W:0]   rem_r;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W-1:0] rem_sub;
  logic [QW-1:0]     q_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  // Trial subtract of the divisor
  assign ge      = (rem_r >= {1'b0, den_r});
  assign rem_sub = ge ? DATA_W'(rem_r - {1'b0, den_r}) : rem_r[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // Flag the cycle after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == DIV_CW'(QW - 1));
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= {1'b0, num};
        den_r  <= den;
        q_r    <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= {rem_sub, 1'b0};
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(QW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;

endmodule

### rtl/atd_cordic.sv
// ----------------------------------------------------------------------------
// atd_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle, with a half-turn
// pre-rotation for negative x and a rounded result in FRAC_BITS format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atd_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [atd_pkg::UW-1:0]    y_in,
  input  logic signed [atd_pkg::UW-1:0]    x_in,
  output atd_pkg::unit_stat_t              stat,
  output logic [atd_pkg::ANG_W-1:0]        angle
);
  import atd_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

  cstate_t              state_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic [IT_W-1:0]      it_r;
  logic                 done_r;
  logic [ANG_W-1:0]     angle_r;
  logic signed [XW-1:0] xk;
  logic signed [XW-1:0] yk;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zs;
  logic                 y_pos;

  // Scale inputs to Q30 and form the shifted terms
  assign xk    = XW'(x_in) <<< KSH;
  assign yk    = XW'(y_in) <<< KSH;
  assign dx    = x_r >>> it_r;
  assign dy    = y_r >>> it_r;
  assign y_pos = !y_r[XW-1] && (y_r != '0);
  assign zr    = z_r + Z_RND;
  assign zs    = zr >>> KSH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == C_FIN);
      case (state_r)
        C_IDLE: begin
          if (start) begin
            it_r <= '0;
            if (x_in == '0 && y_in == '0) begin
              z_r     <= '0;
              state_r <= C_FIN;
            end else if (x_in[UW-1]) begin
              x_r     <= -xk;
              y_r     <= -yk;
              z_r     <= y_in[UW-1] ? -PI_Q30 : PI_Q30;
              state_r <= C_RUN;
            end else begin
              x_r     <= xk;
              y_r     <= yk;
              z_r     <= '0;
              state_r <= C_RUN;
            end
          end
        end
        C_RUN: begin
          // Rotate toward the x axis
          if (y_pos) begin
            x_r <= x_r + dy;
            y_r <= y_r - dx;
            z_r <= z_r + atan_q30(5'(it_r));
          end else begin
            x_r <= x_r - dy;
            y_r <= y_r + dx;
            z_r <= z_r - atan_q30(5'(it_r));
          end
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(CORDIC_ITERS - 1)) begin
            state_r <= C_FIN;
          end
        end
        C_FIN: begin
          angle_r <= zs[ANG_W-1:0];
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = done_r;
  assign angle     = angle_r;

endmodule

### rtl/affine_transform_decompose_unit.sv
// ----------------------------------------------------------------------------
// affine_transform_decompose_unit
// Splits a 4x4 column-major Q16.16 transform into translation, scale and
// XYZ Euler angles.
//
// Input channel: one request per matrix column, column number in in_tuser.
// Columns 0 to 2 are stored and give no result; column 3 starts the
// decomposition and gives exactly one result request.
// The decomposition runs three lengths (squares plus a serial root of
// 32 bits), seven unit elements (serial divider of FRAC_BITS+1 quotient
// bits), the cosine root and three CORDIC runs; gimbal lock skips one run
// and a zero-length column stops after the lengths.
// Missing columns or a zero corner go straight to the result state.
// in_tready is low while a decomposition runs, so the unit takes no new
// columns until its result is in the output register.
// The result sits in an output register; while the receiver stalls the unit
// still takes columns and may compute the next matrix up to its result.
// Reset clears the column-seen flags and out_tvalid and returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_transform_decompose_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // elem_x [31:0], elem_y [63:32], elem_z [95:64], elem_w [127:96]
  input  logic [atd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // column_index [1:0]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // trans_x [31:0], trans_y [63:32], trans_z [95:64], angle_x [114:96],
  // angle_y [133:115], angle_z [152:134], scale_x [183:153],
  // scale_y [214:184], scale_z [245:215], zero [247:246]
  output logic [atd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status [1:0]
  output logic [1:0]                         out_tuser
);
  import atd_pkg::*;

  `include "affine_transform_decompose_unit_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_SQRT, S_CHECK, S_DLOAD, S_DWAIT,
    S_TM, S_TMSUB, S_TMSQRT, S_CLOAD, S_CWAIT, S_FINISH
  } state_t;

  localparam logic [1:0]        COL_T  = 2'd3;
  localparam logic [UW-1:0]     ONE_U  = UW'(64'd1 << FRAC_BITS);
  localparam logic [RAD_W-1:0]  ONE_SQ = 64'd1 << (2 * FRAC_BITS);

  // Unit vector element slots
  localparam logic [2:0] U00 = 3'd0;
  localparam logic [2:0] U01 = 3'd1;
  localparam logic [2:0] U02 = 3'd2;
  localparam logic [2:0] U11 = 3'd3;
  localparam logic [2:0] U12 = 3'd4;
  localparam logic [2:0] U20 = 3'd5;
  localparam logic [2:0] U22 = 3'd6;

  // Store entry of each unit element
  function automatic logic [3:0] div_idx(input logic [2:0] d);
    logic [3:0] r;
    case (d)
      U00:     r = 4'd0;
      U01:     r = 4'd1;
      U02:     r = 4'd2;
      U11:     r = 4'd4;
      U12:     r = 4'd5;
      U20:     r = 4'd6;
      U22:     r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Column (and length) of each unit element
  function automatic logic [1:0] div_col(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      U00, U01, U02: r = 2'd0;
      U11, U12:      r = 2'd1;
      default:       r = 2'd2;
    endcase
    return r;
  endfunction

  state_t                  state_r;
  logic [DATA_W-1:0]       store_r [9];
  logic [2:0]              seen_r;
  logic [DATA_W-1:0]       trans_r [3];
  logic [1:0]              status_r;
  logic [3:0]              idx_r;
  logic [1:0]              j_r;
  logic [1:0]              col_r;
  logic [RAD_W-1:0]        acc_r;
  logic [RAD_W-1:0]        prod_r;
  logic [ROOT_W-1:0]       len_r [3];
  logic signed [UW-1:0]    u_r [7];
  logic [2:0]              div_r;
  logic [1:0]              cord_r;
  logic [UW-1:0]           s_r;
  logic [ANG_W-1:0]        ang_r [3];
  logic                    gimbal_r;
  logic                    sq_start_r;
  logic [RAD_W-1:0]        sq_rad_r;
  logic                    dv_start_r;
  logic [DATA_W-1:0]       dv_num_r;
  logic [DATA_W-1:0]       dv_den_r;
  logic                    dv_neg_r;
  logic                    co_start_r;
  logic signed [UW-1:0]    co_y_r;
  logic signed [UW-1:0]    co_x_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [1:0]              out_user_r;

  logic                    in_acc;
  logic [1:0]              col_in;
  logic [3:0]              base;
  logic signed [DATA_W-1:0] rd_e;
  logic signed [DATA_W-1:0] mul_op;
  logic signed [RAD_W-1:0]  sq_full;
  logic [RAD_W-1:0]        acc_sum;
  logic [UW-1:0]           tm;
  logic signed [UW-1:0]    q_ext;
  logic [SCALE_W-1:0]      sc [3];
  logic                    keep_tr;
  logic                    keep_ang;

  unit_stat_t              sq_stat;
  unit_stat_t              dv_stat;
  unit_stat_t              co_stat;
  logic [ROOT_W-1:0]       sq_root;
  logic [QW-1:0]           dv_q;
  logic [ANG_W-1:0]        co_angle;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign col_in    = in_tuser;
  assign base      = {2'b00, col_in} + {1'b0, col_in, 1'b0};

  // Single read port of the column store, shared by squaring and division
  assign rd_e    = store_r[idx_r];
  assign mul_op  = (state_r == S_TM) ? DATA_W'(tm) : rd_e;
  assign sq_full = mul_op * mul_op;
  assign acc_sum = ((j_r == 2'd0) ? '0 : acc_r) + prod_r;
  assign tm      = u_r[U02][UW-1] ? UW'(-u_r[U02]) : UW'(u_r[U02]);
  assign q_ext   = UW'(dv_q);

  // Saturate lengths to the scale width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc[i] = len_r[i][ROOT_W-1] ? {SCALE_W{1'b1}} : len_r[i][SCALE_W-1:0];
    end
  end

  assign keep_tr  = (status_r == ST_OK) || (status_r == ST_ZERO_LEN);
  assign keep_ang = (status_r == ST_OK);

  // Column store: x, y, z of columns 0 to 2
  always_ff @(posedge clk) begin
    if (in_acc && col_in != COL_T) begin
      store_r[base]        <= in_tdata[31:0];
      store_r[base + 4'd1] <= in_tdata[63:32];
      store_r[base + 4'd2] <= in_tdata[95:64];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      sq_start_r  <= 1'b0;
      dv_start_r  <= 1'b0;
      co_start_r  <= 1'b0;
    end else begin
      // Pulse the unit starts from the launching states
      sq_start_r <= ((state_r == S_ACC) && (j_r == 2'd2)) || (state_r == S_TMSUB);
      dv_start_r <= (state_r == S_DLOAD);
      co_start_r <= (state_r == S_CLOAD);
      if (out_valid_r && out_tready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (col_in != COL_T) begin
              seen_r <= seen_r | (3'b001 << col_in);
            end else begin
              seen_r     <= '0;
              trans_r[0] <= in_tdata[31:0];
              trans_r[1] <= in_tdata[63:32];
              trans_r[2] <= in_tdata[95:64];
              ang_r[0]   <= '0;
              ang_r[1]   <= '0;
              ang_r[2]   <= '0;
              idx_r      <= '0;
              j_r        <= '0;
              col_r      <= '0;
              if (seen_r != 3'b111) begin
                status_r <= ST_MISSING;
                state_r  <= S_FINISH;
              end else if (in_tdata[127:96] == '0) begin
                status_r <= ST_CORNER;
                state_r  <= S_FINISH;
              end else begin
                status_r <= ST_OK;
                state_r  <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          prod_r  <= sq_full;
          state_r <= S_ACC;
        end
        S_ACC: begin
          // Sum the squares of one column, then take its root
          acc_r <= acc_sum;
          idx_r <= idx_r + 4'd1;
          if (j_r == 2'd2) begin
            j_r      <= '0;
            sq_rad_r <= acc_sum;
            state_r  <= S_SQRT;
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            len_r[col_r] <= sq_root;
            if (col_r == 2'd2) begin
              state_r <= S_CHECK;
            end else begin
              col_r   <= col_r + 2'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_CHECK: begin
          div_r <= U00;
          idx_r <= div_idx(U00);
          if (len_r[0] == '0 || len_r[1] == '0 || len_r[2] == '0) begin
            status_r <= ST_ZERO_LEN;
            state_r  <= S_FINISH;
          end else begin
            state_r <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dv_num_r <= rd_e[DATA_W-1] ? DATA_W'(-rd_e) : DATA_W'(rd_e);
          dv_neg_r <= rd_e[DATA_W-1];
          dv_den_r <= len_r[div_col(div_r)];
          state_r  <= S_DWAIT;
        end
        S_DWAIT: begin
          if (dv_stat.done) begin
            u_r[div_r] <= dv_neg_r ? -q_ext : q_ext;
            if (div_r == U22) begin
              state_r <= S_TM;
            end else begin
              div_r   <= div_r + 3'd1;
              idx_r   <= div_idx(div_r + 3'd1);
              state_r <= S_DLOAD;
            end
          end
        end
        S_TM: begin
          prod_r  <= sq_full;
          state_r <= S_TMSUB;
        end
        S_TMSUB: begin
          sq_rad_r <= ONE_SQ - prod_r;
          state_r  <= S_TMSQRT;
        end
        S_TMSQRT: begin
          if (sq_stat.done) begin
            s_r      <= sq_root[UW-1:0];
            gimbal_r <= (tm == ONE_U);
            cord_r   <= 2'd0;
            state_r  <= S_CLOAD;
          end
        end
        S_CLOAD: begin
          // Pick the operand pair of the next angle
          case (cord_r)
            2'd0: begin
              co_y_r <= -u_r[U02];
              co_x_r <= s_r;
            end
            2'd1: begin
              if (gimbal_r) begin
                co_y_r <= -u_r[U20];
                co_x_r <= u_r[U11];
              end else begin
                co_y_r <= u_r[U12];
                co_x_r <= u_r[U22];
              end
            end
            default: begin
              co_y_r <= u_r[U01];
              co_x_r <= u_r[U00];
            end
          endcase
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (co_stat.done) begin
            case (cord_r)
              2'd0: begin
                ang_r[1] <= co_angle;
                cord_r   <= 2'd1;
                state_r  <= S_CLOAD;
              end
              2'd1: begin
                ang_r[0] <= co_angle;
                cord_r   <= 2'd2;
                state_r  <= gimbal_r ? S_FINISH : S_CLOAD;
              end
              default: begin
                ang_r[2] <= co_angle;
                state_r  <= S_FINISH;
              end
            endcase
          end
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= status_r;
            out_data_r  <= {
              2'b00,
              keep_tr  ? sc[2]      : SCALE_W'(0),
              keep_tr  ? sc[1]      : SCALE_W'(0),
              keep_tr  ? sc[0]      : SCALE_W'(0),
              keep_ang ? ang_r[2]   : ANG_W'(0),
              keep_ang ? ang_r[1]   : ANG_W'(0),
              keep_ang ? ang_r[0]   : ANG_W'(0),
              keep_tr  ? trans_r[2] : DATA_W'(0),
              keep_tr  ? trans_r[1] : DATA_W'(0),
              keep_tr  ? trans_r[0] : DATA_W'(0)
            };
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  atd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (sq_rad_r),
    .stat     (sq_stat),
    .root     (sq_root)
  );

  atd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start_r),
    .num   (dv_num_r),
    .den   (dv_den_r),
    .stat  (dv_stat),
    .quo   (dv_q)
  );

  atd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (co_start_r),
    .y_in  (co_y_r),
    .x_in  (co_x_r),
    .stat  (co_stat),
    .angle (co_angle)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `ATDU_ASSERT_IMPL(a_idle_units_quiet, in_tready,
    !(sq_stat.busy || dv_stat.busy || co_stat.busy),
    "arithmetic unit busy while taking columns")
  `ATDU_ASSERT_NEXT(a_seen_cleared, in_tvalid && in_tready && in_tuser == COL_T,
    seen_r == 3'b000, "column flags not cleared by column 3")
  `ATDU_ASSERT_IMPL(a_missing_zero, out_tvalid && out_tuser == ST_MISSING,
    out_tdata == '0, "result with missing columns carries data")

endmodule

### tb/tb_affine_transform_decompose_unit.sv
// ----------------------------------------------------------------------------
// tb_affine_transform_decompose_unit
// Streams matrix columns into the decomposition unit, predicts each result
// (translation, scale, Euler angles, status) and checks the whole of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_affine_transform_decompose_unit;
  import atd_pkg::*;

  localparam longint PI30 = 64'sd3373259426;
  localparam int MAX_CYCLES = 3_000_000;

  typedef struct packed {
    logic [1:0]  col;
    logic [31:0] ex, ey, ez, ew;
  } column_req_t;

  typedef struct packed {
    logic [31:0] tx, ty, tz;
    logic [18:0] ax, ay, az;
    logic [30:0] sx, sy, sz;
    logic [1:0]  st;
  } decomp_res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser, out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic in_tready_q;

  affine_transform_decompose_unit uut (.*);

  column_req_t pending_cols[$];
  decomp_res_t expected_decomps[$];
  int     errors, mismatch_cnt;
  longint cycles;
  bit     no_idle, stim_done;
  int     send_gap, recv_gap;

  // predictor state
  logic [31:0] col_mem[9];
  logic [2:0]  seen_mask;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[30] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h8, 64'h4, 64'h2};
    return t[i];
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    y = y * (64'sd1 <<< (30 - FRAC_BITS));
    x = x * (64'sd1 <<< (30 - FRAC_BITS));
    if (x < 0) begin
      z = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dx = floor_sh(x, i);
      dy = floor_sh(y, i);
      if (y > 0) begin
        x += dy; y -= dx; z += atan_tab(i);
      end else begin
        x -= dy; y += dx; z -= atan_tab(i);
      end
    end
    return floor_sh(z + (64'sd1 <<< (29 - FRAC_BITS)), 30 - FRAC_BITS);
  endfunction

  function automatic longint unit_elem(longint e, longint unsigned len);
    longint unsigned mag, q;
    mag = (e < 0) ? -e : e;
    q = (mag << FRAC_BITS) / len;
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    return (e < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Update the column store; return 1 with the decomposition for column 3
  function automatic bit decompose_column(column_req_t c, output decomp_res_t r);
    longint e[3][3], u[3][3], ang[3], t, tm, one;
    longint unsigned len[3], sc[3], sum;
    logic [1:0] st;
    r = '0;
    if (c.col != 2'd3) begin
      col_mem[c.col*3]   = c.ex;
      col_mem[c.col*3+1] = c.ey;
      col_mem[c.col*3+2] = c.ez;
      seen_mask[c.col] = 1'b1;
      return 0;
    end
    ang = '{0, 0, 0};
    sc = '{0, 0, 0};
    st = ST_OK;
    one = 64'sd1 <<< FRAC_BITS;
    if (seen_mask != 3'b111) st = ST_MISSING;
    else if (c.ew == 0) st = ST_CORNER;
    else begin
      r.tx = c.ex; r.ty = c.ey; r.tz = c.ez;
      for (int i = 0; i < 3; i++) begin
        sum = 0;
        for (int j = 0; j < 3; j++) begin
          e[i][j] = longint'(signed'(col_mem[i*3+j]));
          sum += longint'(e[i][j] * e[i][j]);
        end
        len[i] = int_sqrt(sum);
        sc[i] = (len[i] > 64'h7FFFFFFF) ? 64'h7FFFFFFF : len[i];
        if (len[i] == 0) st = ST_ZERO_LEN;
      end
      if (st == ST_OK) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) u[i][j] = unit_elem(e[i][j], len[i]);
        t = -u[0][2];
        tm = (t < 0) ? -t : t;
        ang[1] = cordic_atan2(t, int_sqrt(one * one - tm * tm));
        if (tm < one) begin
          ang[0] = cordic_atan2(u[1][2], u[2][2]);
          ang[2] = cordic_atan2(u[0][1], u[0][0]);
        end else begin
          ang[0] = cordic_atan2(-u[2][0], u[1][1]);
        end
      end
    end
    seen_mask = '0;
    r.ax = ang[0][18:0]; r.ay = ang[1][18:0]; r.az = ang[2][18:0];
    r.sx = sc[0][30:0]; r.sy = sc[1][30:0]; r.sz = sc[2][30:0];
    r.st = st;
    return 1;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic push_col(int c, logic [31:0] x, y, z, w);
    column_req_t q;
    q.col = 2'(c); q.ex = x; q.ey = y; q.ez = z; q.ew = w;
    pending_cols.push_back(q);
  endtask

  task automatic push_matrix(logic [31:0] m[12], logic [31:0] corner);
    for (int c = 0; c < 3; c++) push_col(c, m[c*3], m[c*3+1], m[c*3+2], $urandom);
    push_col(3, m[9], m[10], m[11], corner);
  endtask

  // Stimulus
  initial begin
    logic [31:0] m[12];
    int order[3], tmp, k;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0; out_tready = 0;
    rst_n = 0; errors = 0; mismatch_cnt = 0; cycles = 0;
    no_idle = 0; stim_done = 0; send_gap = 0; recv_gap = 0;
    seen_mask = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: columns missing, identity, gimbal lock, zero corner/column, extremes
    push_col(3, 32'h1, 32'h2, 32'h3, 32'h10000);
    push_col(0, 32'h10000, 0, 0, 0);
    push_col(3, 0, 0, 0, 32'h10000);
    m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000,
          32'h7FFFFFFF, 32'h80000000, 32'h12345};
    push_matrix(m, 32'h10000);
    m = '{0, 0, 32'hFFFF0000, 0, 32'h10000, 0, 32'h10000, 0, 0, 5, 6, 7};
    push_matrix(m, 32'h10000);
    m = '{0, 0, 32'h10000, 0, 32'h10000, 0, 32'hFFFF0000, 0, 0, 5, 6, 7};
    push_matrix(m, 32'hFFFFFFFF);
    push_matrix(m, 32'h0);
    m = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0, 1, 1, 1};
    push_matrix(m, 32'h80000000);
    m = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
          32'h80000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    push_matrix(m, 32'h7FFFFFFF);

    // pause until the pipeline drains
    wait (pending_cols.size() == 0 && !in_tvalid && expected_decomps.size() == 0);
    // random: mostly full matrices in shuffled order, some noise
    k = 0;
    while (k < 600) begin
      if ($urandom_range(0, 9) < 8) begin
        order = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
          tmp = $urandom_range(0, i);
          {order[i], order[tmp]} = {order[tmp], order[i]};
        end
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(0, 19) == 0) push_col(order[i], 0, 0, 0, $urandom);
          else push_col(order[i], rand_elem(), rand_elem(), rand_elem(), $urandom);
        end
        push_col(3, rand_elem(), rand_elem(), rand_elem(),
                 ($urandom_range(0, 15) == 0) ? 32'h0 : rand_elem());
        k += 4;
      end else begin
        push_col($urandom_range(0, 3), rand_elem(), rand_elem(), rand_elem(),
                 rand_elem());
        k += 1;
      end
    end
    stim_done = 1;
    // run the last part without idling
    wait (pending_cols.size() < 120);
    no_idle = 1;
  end

  // Driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_q) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 0;
        end else if (pending_cols.size() != 0 &&
                     !(no_idle == 0 && $urandom_range(0, 7) == 0)) begin
          in_tvalid <= 1;
          in_tuser  <= pending_cols[0].col;
          in_tdata  <= {pending_cols[0].ew, pending_cols[0].ez,
                        pending_cols[0].ey, pending_cols[0].ex};
          void'(pending_cols.pop_front());
        end else begin
          in_tvalid <= 0;
          if (!no_idle && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 4);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // Monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    column_req_t c;
    decomp_res_t want, got;
    cycles <= cycles + 1;
    in_tready_q <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      c.col = in_tuser;
      {c.ew, c.ez, c.ey, c.ex} = in_tdata;
      if (decompose_column(c, want)) expected_decomps.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.tx = out_tdata[31:0];    got.ty = out_tdata[63:32];
      got.tz = out_tdata[95:64];   got.ax = out_tdata[114:96];
      got.ay = out_tdata[133:115]; got.az = out_tdata[152:134];
      got.sx = out_tdata[183:153]; got.sy = out_tdata[214:184];
      got.sz = out_tdata[245:215]; got.st = out_tuser;
      if (expected_decomps.size() == 0) begin
        errors++;
        if (mismatch_cnt++ < 10) $display("unexpected result %h", got);
      end else begin
        want = expected_decomps.pop_front();
        if (got !== want || out_tdata[247:246] !== 2'b00) begin
          errors++;
          if (mismatch_cnt++ < 10)
            $display("mismatch: exp %h got %h", want, got);
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done && pending_cols.size() == 0 && !in_tvalid &&
          expected_decomps.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_decomps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    wait (cycles >= MAX_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/atd_pkg.sv
rtl/atd_sqrt.sv
rtl/atd_div.sv
rtl/atd_cordic.sv
rtl/affine_transform_decompose_unit.sv
tb/tb_affine_transform_decompose_unit.sv
